@@ rtl/ipap_pkg.sv @@
// ----------------------------------------------------------------------------
// ipap_pkg
// Shared types and constants of the IP address text parser.
// ----------------------------------------------------------------------------
package ipap_pkg;

   // Address families as sampled on the first character of a string.
   localparam logic [1:0] FAMILY_IPV4 = 2'd0;
   localparam logic [1:0] FAMILY_IPV6 = 2'd1;

   // Result status codes.
   localparam logic [1:0] STATUS_VALID       = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   // Characters the grammar knows.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Number rules.
   localparam logic [11:0] MAX_OCTET      = 12'd255;
   localparam logic [11:0] DEC_RADIX      = 12'd10;
   localparam logic [3:0]  HEX_LETTER_LOW = 4'd10;
   localparam logic [1:0]  MAX_DEC_DIGITS = 2'd3;
   localparam logic [2:0]  MAX_HEX_DIGITS = 3'd4;
   localparam logic [1:0]  QUAD_LAST      = 2'd3;

   // Address buffer geometry.
   localparam int          NUM_BYTES  = 16;
   localparam logic [4:0]  ADDR_BYTES = 5'd16;
   localparam logic [4:0]  GROUP_SIZE = 5'd2;
   localparam logic [4:0]  QUAD_SIZE  = 5'd4;

   // Request and response transactions.
   typedef struct packed {
      logic [1:0] family;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] address_high;
      logic [63:0] address_low;
   } rsp_type;

   // Byte 0 of the address sits in the most significant position.
   typedef logic [0:NUM_BYTES-1][7:0] addr_bytes_type;

   // Character classification.
   typedef struct packed {
      logic       is_nul;
      logic       is_dec;
      logic       is_hex;
      logic       is_colon;
      logic       is_dot;
      logic [3:0] hex_val;
   } char_class_type;

   // Decimal part accumulator.
   typedef struct packed {
      logic [7:0] val;
      logic [1:0] cnt;
      logic       ok;
      logic       lz;
   } dec_state_type;

   localparam dec_state_type DEC_CLEAR = '{val: 8'd0, cnt: 2'd0, ok: 1'b1, lz: 1'b0};

   // Parser phase.
   typedef enum logic [2:0] {
      PH_START,
      PH_V4,
      PH_LEAD,
      PH_V6,
      PH_SEP,
      PH_QUAD,
      PH_BAD,
      PH_UNSUP
   } parse_phase_type;

   // Result produced by the parser core for one character.
   typedef struct packed {
      logic    fire;
      rsp_type rsp;
   } parse_result_type;

endpackage

@@ rtl/ipap_char_decode.sv @@
// ----------------------------------------------------------------------------
// ipap_char_decode
// Classifies one text character as digit, hex digit, colon, dot or NUL.
// ----------------------------------------------------------------------------
module ipap_char_decode (
   input  logic [7:0]               ch,
   output ipap_pkg::char_class_type cls
);

   logic [7:0] lower_off;
   logic [7:0] upper_off;
   logic [7:0] digit_off;

   assign digit_off = ch - ipap_pkg::CHAR_DIGIT_0;
   assign lower_off = ch - ipap_pkg::CHAR_LOWER_A;
   assign upper_off = ch - ipap_pkg::CHAR_UPPER_A;

   // Range checks and the nibble value of a hex digit.
   always_comb begin
      cls          = '0;
      cls.is_nul   = (ch == ipap_pkg::CHAR_NUL);
      cls.is_colon = (ch == ipap_pkg::CHAR_COLON);
      cls.is_dot   = (ch == ipap_pkg::CHAR_DOT);
      if (ch >= ipap_pkg::CHAR_DIGIT_0 && ch <= ipap_pkg::CHAR_DIGIT_9) begin
         cls.is_dec  = 1'b1;
         cls.is_hex  = 1'b1;
         cls.hex_val = digit_off[3:0];
      end else if (ch >= ipap_pkg::CHAR_LOWER_A && ch <= ipap_pkg::CHAR_LOWER_F) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = lower_off[3:0] + ipap_pkg::HEX_LETTER_LOW;
      end else if (ch >= ipap_pkg::CHAR_UPPER_A && ch <= ipap_pkg::CHAR_UPPER_F) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = upper_off[3:0] + ipap_pkg::HEX_LETTER_LOW;
      end
   end

endmodule

@@ rtl/ipap_gap_expand.sv @@
// ----------------------------------------------------------------------------
// ipap_gap_expand
// Moves the bytes after a "::" gap to the end of the address and fills the
// gap with zeros; also checks the final byte count.
// ----------------------------------------------------------------------------
module ipap_gap_expand (
   input  ipap_pkg::addr_bytes_type bytes,
   input  logic [4:0]               wp,
   input  logic                     gap_seen,
   input  logic [4:0]               gap_pos,
   output logic                     ok,
   output ipap_pkg::addr_bytes_type addr
);

   // Without a gap the buffer must be full; with one it must have room.
   assign ok = gap_seen ? (wp < ipap_pkg::ADDR_BYTES && gap_pos <= wp)
                        : (wp == ipap_pkg::ADDR_BYTES);

   // Each output byte picks from the head, the shifted tail or zero.
   always_comb begin
      logic [5:0] reach;
      logic [3:0] src;
      reach = 6'd0;
      src   = 4'd0;
      addr  = bytes;
      if (gap_seen) begin
         for (int i = 0; i < ipap_pkg::NUM_BYTES; i++) begin
            reach = 6'(i) + {1'b0, wp};
            src   = 4'(i) + wp[3:0];
            if (5'(i) < gap_pos) begin
               addr[i] = bytes[i];
            end else if (reach >= ({1'b0, ipap_pkg::ADDR_BYTES} + {1'b0, gap_pos})) begin
               addr[i] = bytes[src];
            end else begin
               addr[i] = 8'd0;
            end
         end
      end
   end

endmodule

@@ rtl/ipap_parser.sv @@
// ----------------------------------------------------------------------------
// ipap_parser
// Parse state of one address string, advanced one character per step, and
// the result built when the NUL arrives.
// ----------------------------------------------------------------------------
module ipap_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  ipap_pkg::req_type          item,
   output ipap_pkg::parse_result_type result
);

   typedef struct packed {
      logic                    fail;
      ipap_pkg::dec_state_type next;
   } dec_push_type;

   ipap_pkg::char_class_type  cls;
   ipap_pkg::parse_phase_type ph_eff;
   logic [1:0]                fam_eff;
   logic                      lead_hold;

   ipap_pkg::addr_bytes_type  bytes_ff,    bytes_in;
   logic [4:0]                wp_ff,       wp_in;
   logic                      gap_seen_ff, gap_seen_in;
   logic [4:0]                gap_pos_ff,  gap_pos_in;
   logic [15:0]               group_ff,    group_in;
   logic [2:0]                hex_cnt_ff,  hex_cnt_in;
   logic                      saw_hex_ff,  saw_hex_in;
   ipap_pkg::dec_state_type   dec_ff,      dec_in;
   logic [1:0]                quad_ff,     quad_in;
   ipap_pkg::parse_phase_type phase_ff,    phase_in;
   logic [1:0]                fam_ff,      fam_in;

   ipap_pkg::addr_bytes_type  fin_bytes;
   logic [4:0]                fin_wp;
   logic                      fin_ok;
   logic                      gap_ok;
   ipap_pkg::addr_bytes_type  gap_addr;

   // Appends one decimal digit to a part, flagging leading zeros, a fourth
   // digit or a value above 255.
   function automatic dec_push_type dec_push(ipap_pkg::dec_state_type cur,
                                             logic [3:0] digit);
      dec_push_type r;
      logic [11:0]  prod;
      prod = 12'(cur.val) * ipap_pkg::DEC_RADIX + 12'(digit);
      r.fail = (cur.cnt != 2'd0 && cur.lz) || (cur.cnt == ipap_pkg::MAX_DEC_DIGITS) ||
               (prod > ipap_pkg::MAX_OCTET);
      r.next     = cur;
      r.next.val = prod[7:0];
      r.next.cnt = cur.cnt + 2'd1;
      if (cur.cnt == 2'd0) begin
         r.next.lz = (digit == 4'd0);
      end
      return r;
   endfunction

   ipap_char_decode u_decode (
      .ch  (item.ch),
      .cls (cls)
   );

   // The first character of a string latches the family and picks the phase.
   always_comb begin
      ph_eff    = phase_ff;
      fam_eff   = fam_ff;
      lead_hold = 1'b0;
      if (phase_ff == ipap_pkg::PH_START) begin
         fam_eff = item.family;
         if (item.family == ipap_pkg::FAMILY_IPV4) begin
            ph_eff = ipap_pkg::PH_V4;
         end else if (item.family == ipap_pkg::FAMILY_IPV6) begin
            if (cls.is_colon) begin
               ph_eff    = ipap_pkg::PH_LEAD;
               lead_hold = 1'b1;
            end else begin
               ph_eff = ipap_pkg::PH_V6;
            end
         end else begin
            ph_eff = ipap_pkg::PH_UNSUP;
         end
      end
   end

   // Next parse state for one non-NUL character; a NUL clears everything.
   always_comb begin
      dec_push_type push;
      logic [3:0]   quad_idx;
      logic [3:0]   wp_idx;
      push        = dec_push(dec_ff, cls.hex_val);
      quad_idx    = wp_ff[3:0] + {2'b00, quad_ff};
      wp_idx      = wp_ff[3:0];
      bytes_in    = bytes_ff;
      wp_in       = wp_ff;
      gap_seen_in = gap_seen_ff;
      gap_pos_in  = gap_pos_ff;
      group_in    = group_ff;
      hex_cnt_in  = hex_cnt_ff;
      saw_hex_in  = saw_hex_ff;
      dec_in      = dec_ff;
      quad_in     = quad_ff;
      phase_in    = ph_eff;
      fam_in      = fam_eff;
      if (lead_hold) begin
         phase_in = ipap_pkg::PH_LEAD;
      end else if (!cls.is_nul) begin
         unique case (ph_eff)
            ipap_pkg::PH_V4, ipap_pkg::PH_QUAD: begin
               if (cls.is_dec) begin
                  if (push.fail) begin
                     phase_in = ipap_pkg::PH_BAD;
                  end else begin
                     dec_in = push.next;
                  end
               end else if (cls.is_dot) begin
                  if (dec_ff.cnt == 2'd0 || quad_ff == ipap_pkg::QUAD_LAST) begin
                     phase_in = ipap_pkg::PH_BAD;
                  end else begin
                     bytes_in[quad_idx] = dec_ff.val;
                     quad_in            = quad_ff + 2'd1;
                     dec_in             = ipap_pkg::DEC_CLEAR;
                  end
               end else begin
                  phase_in = ipap_pkg::PH_BAD;
               end
            end
            ipap_pkg::PH_LEAD: begin
               if (cls.is_colon) begin
                  gap_seen_in = 1'b1;
                  gap_pos_in  = 5'd0;
                  phase_in    = ipap_pkg::PH_V6;
               end else begin
                  phase_in = ipap_pkg::PH_BAD;
               end
            end
            ipap_pkg::PH_V6, ipap_pkg::PH_SEP: begin
               phase_in = ipap_pkg::PH_V6;
               if (cls.is_hex) begin
                  if (hex_cnt_ff == ipap_pkg::MAX_HEX_DIGITS) begin
                     phase_in = ipap_pkg::PH_BAD;
                  end else begin
                     group_in   = {group_ff[11:0], cls.hex_val};
                     hex_cnt_in = hex_cnt_ff + 3'd1;
                     saw_hex_in = 1'b1;
                     // The token may still turn out to be a decimal part.
                     if (dec_ff.ok) begin
                        if (cls.is_dec && !push.fail) begin
                           dec_in = push.next;
                        end else begin
                           dec_in.ok = 1'b0;
                        end
                     end
                  end
               end else if (cls.is_colon) begin
                  if (!saw_hex_ff) begin
                     if (gap_seen_ff) begin
                        phase_in = ipap_pkg::PH_BAD;
                     end else begin
                        gap_seen_in = 1'b1;
                        gap_pos_in  = wp_ff;
                        dec_in      = ipap_pkg::DEC_CLEAR;
                     end
                  end else if (wp_ff > ipap_pkg::ADDR_BYTES - ipap_pkg::GROUP_SIZE) begin
                     phase_in = ipap_pkg::PH_BAD;
                  end else begin
                     bytes_in[wp_idx]        = group_ff[15:8];
                     bytes_in[wp_idx + 4'd1] = group_ff[7:0];
                     wp_in      = wp_ff + ipap_pkg::GROUP_SIZE;
                     group_in   = 16'd0;
                     hex_cnt_in = 3'd0;
                     saw_hex_in = 1'b0;
                     dec_in     = ipap_pkg::DEC_CLEAR;
                     phase_in   = ipap_pkg::PH_SEP;
                  end
               end else if (cls.is_dot && saw_hex_ff &&
                            wp_ff <= ipap_pkg::ADDR_BYTES - ipap_pkg::QUAD_SIZE &&
                            dec_ff.ok && dec_ff.cnt != 2'd0) begin
                  // Start of an embedded dotted quad.
                  bytes_in[wp_idx] = dec_ff.val;
                  quad_in    = 2'd1;
                  saw_hex_in = 1'b0;
                  dec_in     = ipap_pkg::DEC_CLEAR;
                  phase_in   = ipap_pkg::PH_QUAD;
               end else begin
                  phase_in = ipap_pkg::PH_BAD;
               end
            end
            default: begin
            end
         endcase
      end else begin
         bytes_in    = '0;
         wp_in       = 5'd0;
         gap_seen_in = 1'b0;
         gap_pos_in  = 5'd0;
         group_in    = 16'd0;
         hex_cnt_in  = 3'd0;
         saw_hex_in  = 1'b0;
         dec_in      = ipap_pkg::DEC_CLEAR;
         quad_in     = 2'd0;
         phase_in    = ipap_pkg::PH_START;
         fam_in      = ipap_pkg::FAMILY_IPV4;
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff    <= '0;
         wp_ff       <= 5'd0;
         gap_seen_ff <= 1'b0;
         gap_pos_ff  <= 5'd0;
         group_ff    <= 16'd0;
         hex_cnt_ff  <= 3'd0;
         saw_hex_ff  <= 1'b0;
         dec_ff      <= ipap_pkg::DEC_CLEAR;
         quad_ff     <= 2'd0;
         phase_ff    <= ipap_pkg::PH_START;
         fam_ff      <= ipap_pkg::FAMILY_IPV4;
      end else if (step_en) begin
         bytes_ff    <= bytes_in;
         wp_ff       <= wp_in;
         gap_seen_ff <= gap_seen_in;
         gap_pos_ff  <= gap_pos_in;
         group_ff    <= group_in;
         hex_cnt_ff  <= hex_cnt_in;
         saw_hex_ff  <= saw_hex_in;
         dec_ff      <= dec_in;
         quad_ff     <= quad_in;
         phase_ff    <= phase_in;
         fam_ff      <= fam_in;
      end
   end

   // At the NUL, flush the open IPv6 group or the last quad part.
   always_comb begin
      logic [3:0] wp_idx;
      wp_idx    = wp_ff[3:0];
      fin_bytes = bytes_ff;
      fin_wp    = wp_ff;
      fin_ok    = 1'b0;
      if (ph_eff == ipap_pkg::PH_QUAD) begin
         fin_ok = (quad_ff == ipap_pkg::QUAD_LAST) && (dec_ff.cnt != 2'd0);
         fin_bytes[wp_idx + 4'd3] = dec_ff.val;
         fin_wp = wp_ff + ipap_pkg::QUAD_SIZE;
      end else if (ph_eff == ipap_pkg::PH_V6) begin
         if (saw_hex_ff) begin
            fin_ok = (wp_ff <= ipap_pkg::ADDR_BYTES - ipap_pkg::GROUP_SIZE);
            fin_bytes[wp_idx]        = group_ff[15:8];
            fin_bytes[wp_idx + 4'd1] = group_ff[7:0];
            fin_wp = wp_ff + ipap_pkg::GROUP_SIZE;
         end else begin
            fin_ok = 1'b1;
         end
      end
   end

   ipap_gap_expand u_gap (
      .bytes    (fin_bytes),
      .wp       (fin_wp),
      .gap_seen (gap_seen_ff),
      .gap_pos  (gap_pos_ff),
      .ok       (gap_ok),
      .addr     (gap_addr)
   );

   // Result assembly.
   always_comb begin
      result.fire             = cls.is_nul;
      result.rsp.status       = ipap_pkg::STATUS_MALFORMED;
      result.rsp.address_high = 64'd0;
      result.rsp.address_low  = 64'd0;
      if (ph_eff == ipap_pkg::PH_UNSUP) begin
         result.rsp.status = ipap_pkg::STATUS_UNSUPPORTED;
      end else if (ph_eff == ipap_pkg::PH_V4 && fam_eff == ipap_pkg::FAMILY_IPV4) begin
         if (quad_ff == ipap_pkg::QUAD_LAST && dec_ff.cnt != 2'd0) begin
            result.rsp.status      = ipap_pkg::STATUS_VALID;
            result.rsp.address_low = {32'd0, bytes_ff[0], bytes_ff[1], bytes_ff[2],
                                      dec_ff.val};
         end
      end else if (fam_eff == ipap_pkg::FAMILY_IPV6 && fin_ok && gap_ok) begin
         result.rsp.status = ipap_pkg::STATUS_VALID;
         {result.rsp.address_high, result.rsp.address_low} = gap_addr;
      end
   end

endmodule

@@ rtl/ip_address_text_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_parser_unit
// Parses IPv4 and IPv6 address text, one character per transaction, and
// returns the binary address and a status when the NUL arrives.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  ipap_pkg::req_type (family, ch)
//   rsp_     out        rsp_valid/rsp_stall  ipap_pkg::rsp_type (status, address)
//
// One character is taken every cycle unless req_stall is high; a character
// goes from the input register through the parser and the gap expansion
// mux, and a NUL's result is then registered in the output register.
// Reset is synchronous and returns the parser to the start of a string.
// While a result waits under rsp_stall, the pipeline holds and req_stall
// rises once the input register is occupied.
// ----------------------------------------------------------------------------
module ip_address_text_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ipap_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipap_pkg::rsp_type rsp_data
);

   logic                       in_valid_ff, in_valid_in;
   ipap_pkg::req_type          in_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   ipap_pkg::rsp_type          rsp_data_ff;
   logic                       out_free;
   logic                       proc;
   logic                       accept;
   ipap_pkg::parse_result_type result;

   // Pipeline advance control.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Input register occupancy.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   // Output register occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = proc && result.fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (proc && result.fire) begin
         rsp_data_ff <= result.rsp;
      end
   end

   ipap_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (proc),
      .item    (in_data_ff),
      .result  (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A processed NUL always leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (proc && in_data_ff.ch == ipap_pkg::CHAR_NUL) |=> rsp_valid_ff)
      else $error("NUL transaction produced no result");

   // Any other character never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      (proc && in_data_ff.ch != ipap_pkg::CHAR_NUL) |=> !rsp_valid_ff)
      else $error("result produced without a NUL");

   // A failed parse carries an all-zero address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ipap_pkg::STATUS_VALID) |->
      (rsp_data_ff.address_high == 64'd0 && rsp_data_ff.address_low == 64'd0))
      else $error("address not zero on error status");

endmodule
